/* rtl/pprm_pkg.sv */
package pprm_pkg;

  localparam int unsigned NUM_W   = 32;
  localparam int unsigned MAX_W   = 16;
  localparam int unsigned TMO_W   = 25;
  localparam int unsigned RELOAD_W = 8;
  localparam int unsigned RATE_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned STEP_W  = 5;
  localparam int unsigned CMP_W   = 33;

  localparam logic [NUM_W-1:0]    NUM_RESET    = 32'd9600000;
  localparam logic [MAX_W-1:0]    MAX_RESET    = 16'd65248;
  localparam logic [TMO_W-1:0]    TMO_RESET    = 25'h100_0000 + 25'h1_0000;
  localparam logic [RELOAD_W-1:0] RELOAD_RESET = 8'd12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATE_NUM   = 2'd0,
    REG_MAX_RATE   = 2'd1,
    REG_TIMEOUT    = 2'd2,
    REG_RELOAD     = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [NUM_W-1:0]    rate_numerator;
    logic [MAX_W-1:0]    max_rate;
    logic [TMO_W-1:0]    timeout_ticks;
    logic [RELOAD_W-1:0] reload_offset;
  } cfg_t;

  typedef enum logic {
    JOB_RATE    = 1'b0,
    JOB_TIMEOUT = 1'b1
  } job_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_WB   = 2'd2
  } back_state_e;

endpackage

/* rtl/pulse_period_rate_meter.sv */
// Channel   Direction  Handshake              Payload
// ticks     in         push / full            pulse_level_i
// results   out        empty / pop            rate_o, over_range_o, timed_out_o
// config    in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One tick is taken per cycle while the job queue has room; a tick that makes
// no result costs nothing downstream.
// A rate result in the back: idle loads the job, 32 divider steps, write-back
// once the output is free; timeout and zero-period results skip the divider.
// full rises when two jobs (JobDepth) wait, e.g. edges closer than the divider.
// Reset clears counter state and loads the register defaults; cfg_ready_o is 1.
module pulse_period_rate_meter
  import pprm_pkg::*;
#(
  parameter int unsigned CountWidth = 25,
  parameter int unsigned JobDepth   = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic                  pulse_level_i,
  input  logic                  pop,
  output logic                  empty,
  output logic [RATE_W-1:0]     rate_o,
  output logic                  over_range_o,
  output logic                  timed_out_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t                  cfg_q;
  logic                  accept;
  logic                  job_push;
  job_kind_e             job_kind_w;
  logic [CountWidth-1:0] job_period_w;
  logic [CountWidth:0]   jq_wdata, jq_rdata;
  logic                  jq_full, jq_empty, jq_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rate_numerator <= NUM_RESET;
      cfg_q.max_rate       <= MAX_RESET;
      cfg_q.timeout_ticks  <= TMO_RESET;
      cfg_q.reload_offset  <= RELOAD_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_RATE_NUM: cfg_q.rate_numerator <= cfg_data_i;
        REG_MAX_RATE: cfg_q.max_rate       <= cfg_data_i[MAX_W-1:0];
        REG_TIMEOUT:  cfg_q.timeout_ticks  <= cfg_data_i[TMO_W-1:0];
        REG_RELOAD:   cfg_q.reload_offset  <= cfg_data_i[RELOAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign full   = jq_full;
  assign accept = push & ~jq_full;

  pprm_front #(
    .CountWidth(CountWidth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (accept),
    .level_i     (pulse_level_i),
    .job_valid_o (job_push),
    .job_kind_o  (job_kind_w),
    .job_period_o(job_period_w)
  );

  assign jq_wdata = {job_kind_w, job_period_w};

  pprm_jobq #(
    .Width(CountWidth + 1),
    .Depth(JobDepth)
  ) u_jobq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (jq_wdata),
    .pop_i  (jq_pop),
    .data_o (jq_rdata),
    .full_o (jq_full),
    .empty_o(jq_empty)
  );

  pprm_back #(
    .CountWidth(CountWidth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_empty_i (jq_empty),
    .job_kind_i  (job_kind_e'(jq_rdata[CountWidth])),
    .job_period_i(jq_rdata[CountWidth-1:0]),
    .job_pop_o   (jq_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .rate_o      (rate_o),
    .over_range_o(over_range_o),
    .timed_out_o (timed_out_o)
  );

  a_no_job_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> !jq_full)
    else $error("job pushed into full queue");

  a_timeout_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && timed_out_o) |-> (rate_o == '0 && !over_range_o))
    else $error("timeout result carries rate or over-range");

  a_over_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && over_range_o) |-> (rate_o == '0 && !timed_out_o))
    else $error("over-range result carries rate or timeout");

  a_pop_only_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jq_pop |-> !jq_empty)
    else $error("back popped an empty job queue");

endmodule

/* rtl/pprm_front.sv */
module pprm_front
  import pprm_pkg::*;
#(
  parameter int unsigned CountWidth = 25
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  accept_i,
  input  logic                  level_i,
  output logic                  job_valid_o,
  output job_kind_e             job_kind_o,
  output logic [CountWidth-1:0] job_period_o
);

  logic                  prev_q, prev_d;
  logic                  rep_q, rep_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic [CountWidth-1:0] count_inc;
  logic [CMP_W-1:0]      tmo_ext;
  logic                  rise;
  logic                  hit;

  assign rise      = level_i & ~prev_q;
  assign count_inc = (&count_q) ? count_q : count_q + CountWidth'(1);
  assign tmo_ext   = {{(CMP_W-TMO_W){1'b0}}, cfg_i.timeout_ticks};
  assign hit       = {{(CMP_W-CountWidth){1'b0}}, count_inc} >= tmo_ext;

  always_comb begin
    prev_d       = prev_q;
    rep_d        = rep_q;
    count_d      = count_q;
    job_valid_o  = 1'b0;
    job_kind_o   = JOB_RATE;
    job_period_o = count_q;
    if (accept_i) begin
      prev_d = level_i;
      if (rise) begin
        count_d     = {{(CountWidth-RELOAD_W){1'b0}}, cfg_i.reload_offset};
        rep_d       = 1'b0;
        job_valid_o = 1'b1;
      end else if (hit) begin
        count_d     = tmo_ext[CountWidth-1:0];
        rep_d       = 1'b1;
        job_valid_o = ~rep_q;
        job_kind_o  = JOB_TIMEOUT;
      end else begin
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 1'b0;
      rep_q   <= 1'b0;
      count_q <= '0;
    end else begin
      prev_q  <= prev_d;
      rep_q   <= rep_d;
      count_q <= count_d;
    end
  end

endmodule

/* rtl/pprm_jobq.sv */
module pprm_jobq
  import pprm_pkg::*;
#(
  parameter int unsigned Width = 26,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

/* rtl/pprm_back.sv */
module pprm_back
  import pprm_pkg::*;
#(
  parameter int unsigned CountWidth = 25
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  job_empty_i,
  input  job_kind_e             job_kind_i,
  input  logic [CountWidth-1:0] job_period_i,
  output logic                  job_pop_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output logic [RATE_W-1:0]     rate_o,
  output logic                  over_range_o,
  output logic                  timed_out_o
);

  back_state_e           state_q, state_d;
  logic [CountWidth-1:0] per_q, per_d;
  logic [CountWidth-1:0] rem_q, rem_d;
  logic [NUM_W-1:0]      quo_q, quo_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic                  out_valid_q, out_valid_d;
  logic [RATE_W-1:0]     rate_q, rate_d;
  logic                  over_q, over_d;
  logic                  tout_q, tout_d;
  logic                  slot_free;
  logic                  per_zero;
  logic                  wr_out;
  logic [CountWidth:0]   shifted;
  logic [CountWidth:0]   trial;
  logic                  ge;
  logic                  too_big;

  assign slot_free = ~out_valid_q | pop_i;
  assign per_zero  = job_period_i == '0;
  assign shifted   = {rem_q, quo_q[NUM_W-1]};
  assign trial     = shifted - {1'b0, per_q};
  assign ge        = shifted >= {1'b0, per_q};
  assign too_big   = quo_q > {{(NUM_W-MAX_W){1'b0}}, cfg_i.max_rate};

  always_comb begin
    state_d   = state_q;
    per_d     = per_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    step_d    = step_q;
    rate_d    = rate_q;
    over_d    = over_q;
    tout_d    = tout_q;
    job_pop_o = 1'b0;
    wr_out    = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!job_empty_i) begin
          if (job_kind_i == JOB_RATE && !per_zero) begin
            job_pop_o = 1'b1;
            per_d     = job_period_i;
            rem_d     = '0;
            quo_d     = cfg_i.rate_numerator;
            step_d    = '0;
            state_d   = BK_DIV;
          end else if (slot_free) begin
            job_pop_o = 1'b1;
            wr_out    = 1'b1;
            rate_d    = '0;
            over_d    = job_kind_i == JOB_RATE;
            tout_d    = job_kind_i == JOB_TIMEOUT;
          end
        end
      end
      BK_DIV: begin
        rem_d  = ge ? trial[CountWidth-1:0] : shifted[CountWidth-1:0];
        quo_d  = {quo_q[NUM_W-2:0], ge};
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(NUM_W - 1)) begin
          state_d = BK_WB;
        end
      end
      BK_WB: begin
        if (slot_free) begin
          wr_out  = 1'b1;
          rate_d  = too_big ? '0 : quo_q[RATE_W-1:0];
          over_d  = too_big;
          tout_d  = 1'b0;
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
    out_valid_d = (out_valid_q & ~pop_i) | wr_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    per_q  <= per_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    rate_q <= rate_d;
    over_q <= over_d;
    tout_q <= tout_d;
  end

  assign empty_o      = ~out_valid_q;
  assign rate_o       = rate_q;
  assign over_range_o = over_q;
  assign timed_out_o  = tout_q;

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
  import pprm_pkg::*;

  localparam int unsigned CNT_W = 25;
  localparam logic [31:0] CNT_MAX = (32'd1 << CNT_W) - 32'd1;
  localparam int unsigned PHASES = 3;
  localparam int unsigned PHASE_TICKS = 50;
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic              ovr;
    logic              tmo;
  } rate_res_t;

  typedef enum logic {
    ROW_TICK = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic                  lvl;
    int unsigned           reps;
    bit                    typed;
    rate_res_t             want;
    cfg_reg_e              idx;
    logic [CFG_DATA_W-1:0] data;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  logic                  pulse_level_i = 1'b0;
  logic                  pop = 1'b0;
  logic                  empty;
  logic [RATE_W-1:0]     rate_o;
  logic                  over_range_o;
  logic                  timed_out_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  pulse_period_rate_meter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .pulse_level_i (pulse_level_i),
    .pop           (pop),
    .empty         (empty),
    .rate_o        (rate_o),
    .over_range_o  (over_range_o),
    .timed_out_o   (timed_out_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // predictor configuration and state
  logic [NUM_W-1:0]    c_num = NUM_RESET;
  logic [MAX_W-1:0]    c_max = MAX_RESET;
  logic [TMO_W-1:0]    c_tmo = TMO_RESET;
  logic [RELOAD_W-1:0] c_reload = RELOAD_RESET;
  logic                m_prev_lvl = 1'b0;
  logic [31:0]         m_ticks = '0;
  logic                m_tmo_seen = 1'b0;

  rate_res_t   pending_rates[$];
  stim_row_t   stim_rows[$];
  int unsigned err_cnt = 0;
  int unsigned ticks_sent = 0;
  int unsigned results_seen = 0;
  int unsigned stall_cycles = 0;
  int unsigned cfg_writes = 0;
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  bit          hold_go = 1'b0;
  bit          hold_done = 1'b0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_err(input string what);
    err_cnt++;
    $display("ERROR @%0t: %s", $time, what);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic predict_rate(input logic lvl, output bit got, output rate_res_t r);
    logic        rise;
    logic [31:0] period;
    logic [31:0] quot;
    got = 1'b0;
    r = '0;
    rise = lvl && !m_prev_lvl;
    m_prev_lvl = lvl;
    if (rise) begin
      period = m_ticks;
      m_ticks = 32'(c_reload) & CNT_MAX;
      m_tmo_seen = 1'b0;
      got = 1'b1;
      if (period == 32'd0) begin
        r.ovr = 1'b1;
      end else begin
        quot = c_num / period;
        if (quot > 32'(c_max)) r.ovr = 1'b1;
        else r.rate = quot[RATE_W-1:0];
      end
    end else begin
      if (m_ticks < CNT_MAX) m_ticks = m_ticks + 32'd1;
      if (m_ticks >= 32'(c_tmo)) begin
        m_ticks = 32'(c_tmo);
        if (!m_tmo_seen) begin
          got = 1'b1;
          r.tmo = 1'b1;
        end
        m_tmo_seen = 1'b1;
      end
    end
  endtask

  task automatic send_tick(input logic lvl, input bit typed, input rate_res_t want);
    int        g;
    bit        got;
    rate_res_t r;
    g = tx_quiet ? 0 : gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    push <= 1'b1;
    pulse_level_i <= lvl;
    @(posedge clk_i);
    while (full) begin
      stall_cycles++;
      @(posedge clk_i);
    end
    ticks_sent++;
    predict_rate(lvl, got, r);
    if (typed) pending_rates.push_back(want);
    else if (got) pending_rates.push_back(r);
  endtask

  // drain results, then let the back end settle before touching registers
  task automatic wait_idle();
    push <= 1'b0;
    while (pending_rates.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data,
                           input bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (last) cfg_valid_i <= 1'b0;
    cfg_writes++;
    case (idx)
      REG_RATE_NUM: c_num = data[NUM_W-1:0];
      REG_MAX_RATE: c_max = data[MAX_W-1:0];
      REG_TIMEOUT:  c_tmo = data[TMO_W-1:0];
      REG_RELOAD:   c_reload = data[RELOAD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic add_tick(input logic lvl, input int unsigned reps);
    stim_row_t row;
    row = '{kind: ROW_TICK, lvl: lvl, reps: reps, typed: 1'b0, want: '0,
            idx: REG_RATE_NUM, data: '0};
    stim_rows.push_back(row);
  endtask

  task automatic add_want(input logic lvl, input logic [RATE_W-1:0] rate, input logic ovr,
                          input logic tmo);
    stim_row_t row;
    row = '{kind: ROW_TICK, lvl: lvl, reps: 1, typed: 1'b1, want: '{rate, ovr, tmo},
            idx: REG_RATE_NUM, data: '0};
    stim_rows.push_back(row);
  endtask

  task automatic add_cfg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row = '{kind: ROW_CFG, lvl: 1'b0, reps: 0, typed: 1'b0, want: '0, idx: idx, data: data};
    stim_rows.push_back(row);
  endtask

  // result side
  initial begin
    int        g;
    rate_res_t want;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_go && !hold_done) begin
        g = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        g = rx_quiet ? 0 : gap_len();
      end
      if (g > 0) begin
        pop <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      results_seen++;
      if (pending_rates.size() == 0) begin
        report_err("result arrived with nothing expected");
      end else begin
        want = pending_rates.pop_front();
        if (rate_o !== want.rate)
          report_err($sformatf("rate got %0d want %0d", rate_o, want.rate));
        if (over_range_o !== want.ovr)
          report_err($sformatf("over_range got %b want %b", over_range_o, want.ovr));
        if (timed_out_o !== want.tmo)
          report_err($sformatf("timed_out got %b want %b", timed_out_o, want.tmo));
      end
      if (results_seen % 40 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
    end
  end

  // request side
  initial begin
    int unsigned         n;
    int unsigned         k;
    int unsigned         sel;
    int unsigned         lo_run;
    int unsigned         hi_run;
    logic [CFG_DATA_W-1:0] v;

    add_want(1'b1, 16'd0, 1'b1, 1'b0);       // zero period right after reset
    add_tick(1'b0, 135);
    add_want(1'b1, 16'd0, 1'b1, 1'b0);       // 147 ticks: just above default max
    add_tick(1'b0, 136);
    add_want(1'b1, 16'd64864, 1'b0, 1'b0);
    add_tick(1'b1, 2);
    add_cfg(REG_TIMEOUT, 32'd1);
    add_cfg(REG_RELOAD, 32'd0);
    add_want(1'b0, 16'd0, 1'b0, 1'b1);
    add_tick(1'b0, 2);
    add_want(1'b1, 16'd0, 1'b1, 1'b0);       // edge on held count
    add_want(1'b0, 16'd0, 1'b0, 1'b1);
    add_cfg(REG_RATE_NUM, 32'd0);
    add_cfg(REG_TIMEOUT, 32'd0);
    add_want(1'b1, 16'd0, 1'b0, 1'b0);       // zero numerator
    add_want(1'b0, 16'd0, 1'b0, 1'b1);       // zero timeout
    add_want(1'b1, 16'd0, 1'b1, 1'b0);
    add_cfg(REG_RATE_NUM, 32'd196605);
    add_cfg(REG_MAX_RATE, 32'd65535);
    add_cfg(REG_TIMEOUT, 32'h01FF_FFFF);
    add_cfg(REG_RELOAD, 32'd255);
    add_tick(1'b0, 3);
    add_want(1'b1, 16'd65535, 1'b0, 1'b0);
    add_tick(1'b0, 1);
    add_tick(1'b1, 1);
    add_cfg(REG_MAX_RATE, 32'd0);
    add_cfg(REG_RELOAD, 32'd0);
    add_cfg(REG_RATE_NUM, 32'd5);
    add_tick(1'b0, 1);
    add_want(1'b1, 16'd0, 1'b0, 1'b0);
    add_tick(1'b0, 5);
    add_want(1'b1, 16'd0, 1'b1, 1'b0);
    add_cfg(REG_RATE_NUM, 32'hFFFF_FFFF);
    add_cfg(REG_MAX_RATE, 32'd65535);
    add_tick(1'b0, 1);
    add_want(1'b1, 16'd0, 1'b1, 1'b0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        if (i == 0 || stim_rows[i-1].kind != ROW_CFG) wait_idle();
        cfg_write(stim_rows[i].idx, stim_rows[i].data,
                  (i == stim_rows.size() - 1) || (stim_rows[i+1].kind != ROW_CFG));
      end else begin
        repeat (stim_rows[i].reps)
          send_tick(stim_rows[i].lvl, stim_rows[i].typed, stim_rows[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      for (k = 0; k < 4; k++) begin
        sel = $urandom_range(0, 9);
        case (cfg_reg_e'(k[CFG_IDX_W-1:0]))
          REG_RATE_NUM: v = (sel < 2) ? $urandom : (sel == 2) ? 32'hFFFF_FFFF :
                            (sel < 5) ? $urandom_range(1, 2000) : $urandom_range(1000, 4000000);
          REG_MAX_RATE: v = (sel == 0) ? 32'd0 : (sel == 1) ? 32'd65535 :
                            (sel < 5) ? $urandom_range(0, 65535) : $urandom_range(1000, 65535);
          REG_TIMEOUT:  v = (sel == 0) ? 32'd0 : (sel == 1) ? 32'd1 :
                            (sel < 5) ? $urandom_range(2, 64) :
                            (sel < 8) ? $urandom_range(65, 600) :
                            (sel == 8) ? 32'h01FF_FFFF : ($urandom & 32'h01FF_FFFF);
          default:      v = (sel == 0) ? 32'd0 : (sel == 1) ? 32'd255 :
                            (sel < 6) ? $urandom_range(0, 20) : $urandom_range(0, 255);
        endcase
        // first phase keeps the divider busy while results are held off
        if (ph == 0 && k == 2) v = 32'h01FF_FFFF;
        if (ph == 0 && k == 3) v = $urandom_range(1, 255);
        cfg_write(cfg_reg_e'(k[CFG_IDX_W-1:0]), v, k == 3);
      end
      if (ph == 0) hold_go = 1'b1;
      tx_quiet = (ph == 0) || ($urandom_range(0, 3) == 0);
      n = 0;
      while (n < PHASE_TICKS) begin
        if (!(ph == 0 && n < 30) && $urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 8)) begin
            if (n < PHASE_TICKS) begin
              send_tick(1'($urandom_range(0, 1)), 1'b0, '0);
              n++;
            end
          end
        end else begin
          if (ph == 0 && n < 30) begin
            lo_run = 1;
            hi_run = 1;
          end else begin
            lo_run = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 300) :
                     $urandom_range(1, 30);
            hi_run = $urandom_range(1, 4);
          end
          for (k = 0; k < lo_run + hi_run && n < PHASE_TICKS; k++) begin
            send_tick(k >= lo_run, 1'b0, '0);
            n++;
          end
        end
      end
    end

    push <= 1'b0;
    while (pending_rates.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("Ran %0d ticks and %0d register writes over %0d random settings,",
             ticks_sent, cfg_writes, PHASES);
    $display("checked %0d results; input was stalled on %0d cycles.",
             results_seen, stall_cycles);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/pprm_pkg.sv
rtl/pprm_front.sv
rtl/pprm_jobq.sv
rtl/pprm_back.sv
rtl/pulse_period_rate_meter.sv
tb/sv/tb_top.sv
